>>> src/multi_slot_periodic_timer_bank_assert.svh
// assertion macros used by the timer bank checker mspt_check
// depends on nothing; included by mspt_check.sv, which holds the concurrent assertions
`ifndef MULTI_SLOT_PERIODIC_TIMER_BANK_ASSERT_SVH
`define MULTI_SLOT_PERIODIC_TIMER_BANK_ASSERT_SVH

// same-cycle implication
`define MSPT_ASSERT_ALWAYS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer bank check failed");

// next-cycle implication
`define MSPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer bank check failed");

`endif

>>> src/mspt_pkg.sv
// shared types and constants of the periodic timer bank
// no dependencies; used by the interfaces and all modules
`timescale 1ns / 1ps

package mspt_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int FUNC_W        = 2;
    localparam int SLOT_W        = 4;
    localparam int TICK_W        = 32;
    localparam int REP_W         = 16;

    // command queue between front and back, power of two deep
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ARM     = 2'd0,
        FUNC_DISARM  = 2'd1,
        FUNC_ELAPSED = 2'd2,
        FUNC_STATUS  = 2'd3
    } func_t;

    // classified command; ticks holds the elapsed ticks on elapsed, the period otherwise
    typedef struct packed {
        func_t                   func;
        logic [SLOT_W-1:0]       slot;
        logic                    in_range;
        logic [TICK_W-1:0]       ticks;
        logic signed [REP_W-1:0] reps;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } queue_head_t;

endpackage

>>> src/mspt_in_if.sv
// command channel of the timer bank: valid/ready plus command fields
// depends on mspt_pkg
`timescale 1ns / 1ps

interface mspt_in_if;
    import mspt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [FUNC_W-1:0]       func;
    logic [SLOT_W-1:0]       slot_index;
    logic [TICK_W-1:0]       period_ticks;
    logic signed [REP_W-1:0] repeat_count;
    logic [TICK_W-1:0]       elapsed_ticks;

    modport source (
        output valid, func, slot_index, period_ticks, repeat_count, elapsed_ticks,
        input  ready
    );

    modport sink (
        input  valid, func, slot_index, period_ticks, repeat_count, elapsed_ticks,
        output ready
    );
endinterface

>>> src/mspt_out_if.sv
// result channel of the timer bank: valid/ready plus result fields
// depends on mspt_pkg
`timescale 1ns / 1ps

interface mspt_out_if;
    import mspt_pkg::*;

    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] result_slot;
    logic              fired;
    logic              enabled;
    logic              last;

    modport source (
        output valid, result_slot, fired, enabled, last,
        input  ready
    );

    modport sink (
        input  valid, result_slot, fired, enabled, last,
        output ready
    );
endinterface

>>> src/multi_slot_periodic_timer_bank.sv
// top level of the periodic timer bank: front end, command queue and back end
// depends on mspt_pkg, mspt_in_if, mspt_out_if, mspt_front and mspt_back
`timescale 1ns / 1ps

// A bank of NUM_SLOTS timer slots, each with a remaining-tick count, a reload
// period and a signed repeat count (negative repeats forever, zero disables).
// Commands are taken into a two-entry queue, so the command side keeps taking
// transfers while the back end works, until the queue fills. Arm, disarm and
// status each give one result, once the result register is free. An elapsed
// command is taken from the queue as the read of slot 0 starts; the walk then
// reads the slot table one row a cycle, unless it stalls because the result
// side holds off a waiting fired result, and after the last slot the final
// result goes out once the result register is free. Fired slots come out in
// index order with last on the final one, or a single result with fired low
// when none fired. Slot state is cleared by reset through per-slot enable bits.
module multi_slot_periodic_timer_bank #(
    parameter int NUM_SLOTS = mspt_pkg::NUM_SLOTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mspt_in_if.sink    cmd,
    mspt_out_if.source rsp
);
    import mspt_pkg::*;

    queue_head_t head;
    logic        pop;

    mspt_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .head  (head),
        .pop   (pop)
    );

    mspt_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

>>> src/mspt_front.sv
// front end: takes command transfers, classifies them, queues them for the back end
// depends on mspt_pkg and mspt_in_if
`timescale 1ns / 1ps

module mspt_front #(
    parameter int NUM_SLOTS = mspt_pkg::NUM_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    mspt_in_if.sink             cmd,
    output mspt_pkg::queue_head_t head,
    input  logic                pop
);
    import mspt_pkg::*;

    op_t               fifo_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    op_t               op_in;

    assign cmd.ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = cmd.valid && cmd.ready;

    always_comb
    begin
        op_in.func     = func_t'(cmd.func);
        op_in.slot     = cmd.slot_index;
        op_in.in_range = (32'(cmd.slot_index) < NUM_SLOTS);
        op_in.ticks    = (func_t'(cmd.func) == FUNC_ELAPSED) ? cmd.elapsed_ticks
                                                             : cmd.period_ticks;
        op_in.reps     = cmd.repeat_count;
    end

    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = QCNT_W'(count_reg + QCNT_W'(push) - QCNT_W'(pop));
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= op_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.op    = fifo_reg[rd_ptr_reg];

endmodule

>>> src/mspt_back.sv
// back end: slot table, enable bits, elapsed walk and result register
// depends on mspt_pkg and mspt_out_if
`timescale 1ns / 1ps

module mspt_back #(
    parameter int NUM_SLOTS = mspt_pkg::NUM_SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mspt_pkg::queue_head_t head,
    output logic                  pop,
    mspt_out_if.source            rsp
);
    import mspt_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    typedef struct packed {
        logic signed [REP_W-1:0] reps;
        logic [TICK_W-1:0]       reload;
        logic [TICK_W-1:0]       remain;
    } row_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } state_t;

    row_t mem [NUM_SLOTS];
    row_t rd_data_reg;

    state_t            state_reg, state_next;
    logic [NUM_SLOTS-1:0] en_reg, en_next;
    logic [IDX_W-1:0]  exec_idx_reg, exec_idx_next;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0] pend_slot_reg, pend_slot_next;
    logic              pend_en_reg, pend_en_next;
    logic              out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic              out_fired_reg, out_fired_next;
    logic              out_en_reg, out_en_next;
    logic              out_last_reg, out_last_next;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    row_t              mem_wd;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;

    logic              out_free;
    logic [IDX_W-1:0]  head_idx;
    logic              slot_en;
    logic              fire;
    logic signed [REP_W-1:0] reps_dec;
    logic              en_after;
    logic              stall;

    assign out_free = !out_valid_reg || rsp.ready;
    assign head_idx = IDX_W'(head.op.slot);

    // walk datapath on the registered slot read
    assign slot_en  = en_reg[exec_idx_reg];
    assign fire     = (elapsed_reg >= rd_data_reg.remain);
    assign reps_dec = rd_data_reg.reps[REP_W-1] ? rd_data_reg.reps
                                                : REP_W'(rd_data_reg.reps - 1'b1);
    assign en_after = (reps_dec != '0);
    // a second fired slot needs the pending result moved out first
    assign stall    = slot_en && fire && pend_valid_reg && !out_free;

    always_comb
    begin
        state_next      = state_reg;
        en_next         = en_reg;
        exec_idx_next   = exec_idx_reg;
        elapsed_next    = elapsed_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_en_next    = pend_en_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_slot_next   = out_slot_reg;
        out_fired_next  = out_fired_reg;
        out_en_next     = out_en_reg;
        out_last_next   = out_last_reg;
        pop             = 1'b0;
        mem_we          = 1'b0;
        mem_wa          = exec_idx_reg;
        mem_wd          = rd_data_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid && head.op.func == FUNC_ELAPSED)
                begin
                    pop             = 1'b1;
                    rd_en           = 1'b1;
                    rd_addr         = '0;
                    exec_idx_next   = '0;
                    elapsed_next    = head.op.ticks;
                    pend_valid_next = 1'b0;
                    state_next      = ST_WALK;
                end
                else if (head.valid && out_free)
                begin
                    pop            = 1'b1;
                    out_valid_next = 1'b1;
                    out_slot_next  = head.op.slot;
                    out_fired_next = 1'b0;
                    out_last_next  = 1'b1;
                    case (head.op.func)
                        FUNC_ARM:
                        begin
                            if (head.op.in_range)
                            begin
                                mem_we            = 1'b1;
                                mem_wa            = head_idx;
                                mem_wd.reps       = head.op.reps;
                                mem_wd.reload     = head.op.ticks;
                                mem_wd.remain     = head.op.ticks;
                                en_next[head_idx] = (head.op.reps != '0);
                            end
                            out_en_next = head.op.in_range && (head.op.reps != '0);
                        end
                        FUNC_DISARM:
                        begin
                            if (head.op.in_range)
                            begin
                                en_next[head_idx] = 1'b0;
                            end
                            out_en_next = 1'b0;
                        end
                        FUNC_STATUS:
                        begin
                            out_en_next = head.op.in_range && en_reg[head_idx];
                        end
                        default:
                        begin
                            out_en_next = 1'b0;
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                if (!stall)
                begin
                    if (slot_en)
                    begin
                        mem_we = 1'b1;
                        mem_wa = exec_idx_reg;
                        if (fire)
                        begin
                            mem_wd.reps           = reps_dec;
                            mem_wd.remain         = rd_data_reg.reload;
                            en_next[exec_idx_reg] = en_after;
                            if (pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_slot_next  = pend_slot_reg;
                                out_fired_next = 1'b1;
                                out_en_next    = pend_en_reg;
                                out_last_next  = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_slot_next  = SLOT_W'(exec_idx_reg);
                            pend_en_next    = en_after;
                        end
                        else
                        begin
                            mem_wd.remain = rd_data_reg.remain - elapsed_reg;
                        end
                    end
                    if (exec_idx_reg == LAST_IDX)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        rd_en         = 1'b1;
                        rd_addr       = IDX_W'(exec_idx_reg + 1'b1);
                        exec_idx_next = IDX_W'(exec_idx_reg + 1'b1);
                    end
                end
            end

            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    out_fired_next  = pend_valid_reg;
                    out_slot_next   = pend_valid_reg ? pend_slot_reg : '0;
                    out_en_next     = pend_valid_reg && pend_en_reg;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // slot table: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            en_reg         <= '0;
            exec_idx_reg   <= '0;
            elapsed_reg    <= '0;
            pend_valid_reg <= 1'b0;
            pend_slot_reg  <= '0;
            pend_en_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_slot_reg   <= '0;
            out_fired_reg  <= 1'b0;
            out_en_reg     <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            en_reg         <= en_next;
            exec_idx_reg   <= exec_idx_next;
            elapsed_reg    <= elapsed_next;
            pend_valid_reg <= pend_valid_next;
            pend_slot_reg  <= pend_slot_next;
            pend_en_reg    <= pend_en_next;
            out_valid_reg  <= out_valid_next;
            out_slot_reg   <= out_slot_next;
            out_fired_reg  <= out_fired_next;
            out_en_reg     <= out_en_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_slot = out_slot_reg;
    assign rsp.fired       = out_fired_reg;
    assign rsp.enabled     = out_en_reg;
    assign rsp.last        = out_last_reg;

endmodule

>>> src/mspt_check.sv
// port-level checks of the timer bank, bound to the top level
// depends on mspt_pkg and multi_slot_periodic_timer_bank_assert.svh
`timescale 1ns / 1ps
`include "multi_slot_periodic_timer_bank_assert.svh"

module mspt_check (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cmd_valid,
    input logic                        cmd_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [mspt_pkg::SLOT_W-1:0] rsp_slot,
    input logic                        rsp_fired,
    input logic                        rsp_enabled,
    input logic                        rsp_last
);
    import mspt_pkg::*;

    // commands taken whose final result has not been transferred yet
    logic [2:0]        pending_reg, pending_next;
    logic [SLOT_W+2:0] rsp_word;

    assign rsp_word     = {rsp_slot, rsp_fired, rsp_enabled, rsp_last};
    assign pending_next = 3'(pending_reg + 3'(cmd_valid && cmd_ready)
                             - 3'(rsp_valid && rsp_ready && rsp_last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `MSPT_ASSERT_ALWAYS(a_plain_is_last, clk, rst_n, rsp_valid && !rsp_fired, rsp_last)
    `MSPT_ASSERT_ALWAYS(a_no_orphan_rsp, clk, rst_n, rsp_valid, pending_reg != 3'd0)
    `MSPT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `MSPT_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp_word))

endmodule

bind multi_slot_periodic_timer_bank mspt_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_slot    (rsp.result_slot),
    .rsp_fired   (rsp.fired),
    .rsp_enabled (rsp.enabled),
    .rsp_last    (rsp.last)
);
